[hdl/rsdm_pkg.sv]
// Shared types, codes and constants of the redundant stream dedup merger.
package rsdm_pkg;

	localparam int TIME_W   = 48;
	localparam int KEY_W    = 64;
	localparam int TAG_W    = 16;
	localparam int STREAM_W = 8;
	localparam int WIN_W    = 24;
	localparam int MAX_RES  = 32;
	localparam int RES_W    = 6;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_WINDOW = 2'd0;
	localparam logic [1:0] REG_VIDEO  = 2'd1;
	localparam logic [1:0] REG_AUDIO  = 2'd2;

	typedef enum logic [2:0] {
		ACT_VIDEO = 3'd0,
		ACT_AUDIO = 3'd1,
		ACT_DUP   = 3'd2,
		ACT_OTHER = 3'd3,
		ACT_FULL  = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		EK_FULL  = 2'd0,
		EK_DUP   = 2'd1,
		EK_ROUTE = 2'd2
	} emit_kind_t;

	typedef struct packed {
		logic [WIN_W-1:0]    window;
		logic [STREAM_W-1:0] video;
		logic [STREAM_W-1:0] audio;
	} cfg_t;

	typedef struct packed {
		logic                mode;
		logic [TIME_W-1:0]   now;
		logic [TAG_W-1:0]    tag;
		logic [STREAM_W-1:0] stream;
		logic [KEY_W-1:0]    pts;
		logic                pts_valid;
		logic [KEY_W-1:0]    dts;
		logic                dts_valid;
	} in_t;

	// Controller to datapath
	typedef struct packed {
		logic       latch_in;
		logic       insert;
		logic       pop;
		logic       exp_rd;
		logic       exp_adv;
		logic       lk_start;
		logic       lk_rd;
		logic       seen_add;
		logic       emit;
		emit_kind_t kind;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_push;
		logic hold_full;
		logic can_pop;
		logic key_present;
		logic seen_empty;
		logic exp_due;
		logic scan_done;
		logic match;
		logic out_free;
	} sts_t;

endpackage

[hdl/rsdm_dp.sv]
// Datapath: input latch, sorted hold buffer, seen table memory and result register.
module rsdm_dp #(
	parameter int HOLD_DEPTH = 32,
	parameter int SEEN_DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rsdm_pkg::in_t                   in_item,
	input  rsdm_pkg::cfg_t                  cfg,
	input  rsdm_pkg::cmd_t                  cmd,
	output rsdm_pkg::sts_t                  sts,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [rsdm_pkg::TAG_W-1:0]      out_tag,
	output logic [rsdm_pkg::STREAM_W-1:0]   out_stream,
	output rsdm_pkg::action_t               out_action,
	output logic                            out_last,
	output logic [$clog2(HOLD_DEPTH+1)-1:0] hold_cnt,
	output logic [$clog2(SEEN_DEPTH+1)-1:0] seen_cnt
);

	localparam int HC_W  = $clog2(HOLD_DEPTH+1);
	localparam int SA_W  = $clog2(SEEN_DEPTH);
	localparam int SC_W  = $clog2(SEEN_DEPTH+1);
	localparam int SUM_W = SC_W + 1;
	localparam int TW    = rsdm_pkg::TIME_W;
	localparam int KW    = rsdm_pkg::KEY_W;

	typedef struct packed {
		logic [KW-1:0]                  key;
		logic [rsdm_pkg::STREAM_W-1:0]  stream;
		logic [TW-1:0]                  expiry;
	} seen_ent_t;

	// Absent keys sort first; present keys compare as signed values
	function automatic logic key_less(input logic ap, input logic [KW-1:0] a,
			input logic bp, input logic [KW-1:0] b);
		logic r;
		if (!ap) r = bp;
		else if (!bp) r = 1'b0;
		else r = $signed(a) < $signed(b);
		return r;
	endfunction

	function automatic logic [SA_W-1:0] wrap_inc(input logic [SA_W-1:0] a);
		logic [SA_W-1:0] r;
		if (a == SA_W'(SEEN_DEPTH-1)) r = '0;
		else r = a + SA_W'(1);
		return r;
	endfunction

	// Latched input item
	logic                          mode_q;
	logic [TW-1:0]                 now_q;
	logic [rsdm_pkg::TAG_W-1:0]    tag_q;
	logic [rsdm_pkg::STREAM_W-1:0] stream_q;
	logic [KW-1:0]                 key_q;
	logic                          kp_q;

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			mode_q   <= in_item.mode;
			now_q    <= in_item.now;
			tag_q    <= in_item.tag;
			stream_q <= in_item.stream;
			kp_q     <= in_item.pts_valid | in_item.dts_valid;
			if (in_item.pts_valid) key_q <= in_item.pts;
			else if (in_item.dts_valid) key_q <= in_item.dts;
			else key_q <= '0;
		end
	end

	// Sorted hold buffer: a row of cells, entry 0 holds the smallest key
	logic [KW-1:0]                 h_key_q [HOLD_DEPTH];
	logic                          h_kp_q  [HOLD_DEPTH];
	logic [rsdm_pkg::TAG_W-1:0]    h_tag_q [HOLD_DEPTH];
	logic [rsdm_pkg::STREAM_W-1:0] h_str_q [HOLD_DEPTH];
	logic [TW-1:0]                 h_arr_q [HOLD_DEPTH];
	logic [HC_W-1:0]               hold_cnt_q;
	logic [HOLD_DEPTH-1:0]         ins;

	for (genvar i = 0; i < HOLD_DEPTH; i++) begin : g_cell
		assign ins[i] = (HC_W'(i) == hold_cnt_q) || ((HC_W'(i) < hold_cnt_q) &&
			key_less(kp_q, key_q, h_kp_q[i], h_key_q[i]));

		always_ff @(posedge clk) begin
			if (cmd.insert && ins[i]) begin
				if (i > 0 && ins[(i > 0) ? i-1 : 0]) begin
					h_key_q[i] <= h_key_q[(i > 0) ? i-1 : 0];
					h_kp_q[i]  <= h_kp_q[(i > 0) ? i-1 : 0];
					h_tag_q[i] <= h_tag_q[(i > 0) ? i-1 : 0];
					h_str_q[i] <= h_str_q[(i > 0) ? i-1 : 0];
					h_arr_q[i] <= h_arr_q[(i > 0) ? i-1 : 0];
				end else begin
					h_key_q[i] <= key_q;
					h_kp_q[i]  <= kp_q;
					h_tag_q[i] <= tag_q;
					h_str_q[i] <= stream_q;
					h_arr_q[i] <= now_q;
				end
			end else if (cmd.pop && i < HOLD_DEPTH-1) begin
				h_key_q[i] <= h_key_q[(i < HOLD_DEPTH-1) ? i+1 : i];
				h_kp_q[i]  <= h_kp_q[(i < HOLD_DEPTH-1) ? i+1 : i];
				h_tag_q[i] <= h_tag_q[(i < HOLD_DEPTH-1) ? i+1 : i];
				h_str_q[i] <= h_str_q[(i < HOLD_DEPTH-1) ? i+1 : i];
				h_arr_q[i] <= h_arr_q[(i < HOLD_DEPTH-1) ? i+1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt_q <= '0;
		end else if (cmd.insert) begin
			hold_cnt_q <= hold_cnt_q + HC_W'(1);
		end else if (cmd.pop) begin
			hold_cnt_q <= hold_cnt_q - HC_W'(1);
		end
	end

	// Popped packet
	logic [KW-1:0]                 p_key_q;
	logic                          p_kp_q;
	logic [rsdm_pkg::TAG_W-1:0]    p_tag_q;
	logic [rsdm_pkg::STREAM_W-1:0] p_str_q;

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			p_key_q <= h_key_q[0];
			p_kp_q  <= h_kp_q[0];
			p_tag_q <= h_tag_q[0];
			p_str_q <= h_str_q[0];
		end
	end

	// Head is due once held for the window and not in the future
	logic head_due;
	logic [rsdm_pkg::RES_W-1:0] res_cnt_q;

	assign head_due = (hold_cnt_q != '0) && (now_q >= h_arr_q[0]) &&
		((now_q - h_arr_q[0]) >= TW'(cfg.window));

	// Seen table: circular memory with head and fill count
	seen_ent_t       mem [SEEN_DEPTH];
	seen_ent_t       rd_q;
	logic [SA_W-1:0] head_q;
	logic [SC_W-1:0] scnt_q;
	logic [SA_W-1:0] scan_addr_q;
	logic [SC_W-1:0] scan_i_q;
	logic [SA_W-1:0] rd_addr;
	logic [SUM_W-1:0] wsum;
	logic [SA_W-1:0] wr_addr;
	logic [TW:0]     exp_sum;
	logic [TW-1:0]   exp_val;
	logic            seen_full;

	assign rd_addr   = cmd.lk_rd ? scan_addr_q : head_q;
	assign wsum      = SUM_W'(head_q) + SUM_W'(scnt_q);
	assign wr_addr   = (wsum >= SUM_W'(SEEN_DEPTH)) ? SA_W'(wsum - SUM_W'(SEEN_DEPTH))
		: SA_W'(wsum);
	assign exp_sum   = {1'b0, now_q} + (TW+1)'({cfg.window, 1'b0});
	assign exp_val   = exp_sum[TW] ? {TW{1'b1}} : exp_sum[TW-1:0];
	assign seen_full = (scnt_q == SC_W'(SEEN_DEPTH));

	always_ff @(posedge clk) begin
		if (cmd.seen_add) begin
			mem[wr_addr] <= '{key: p_key_q, stream: p_str_q, expiry: exp_val};
		end
		if (cmd.exp_rd || cmd.lk_rd) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			scnt_q <= '0;
		end else if (cmd.exp_adv) begin
			head_q <= wrap_inc(head_q);
			scnt_q <= scnt_q - SC_W'(1);
		end else if (cmd.seen_add) begin
			if (seen_full) head_q <= wrap_inc(head_q);
			else scnt_q <= scnt_q + SC_W'(1);
		end
	end

	// Lookup scan position
	always_ff @(posedge clk) begin
		if (cmd.lk_start) begin
			scan_addr_q <= head_q;
			scan_i_q    <= '0;
		end else if (cmd.lk_rd) begin
			scan_addr_q <= wrap_inc(scan_addr_q);
			scan_i_q    <= scan_i_q + SC_W'(1);
		end
	end

	// Result register
	logic                          out_valid_q;
	logic [rsdm_pkg::TAG_W-1:0]    out_tag_q;
	logic [rsdm_pkg::STREAM_W-1:0] out_str_q;
	rsdm_pkg::action_t             out_act_q;
	logic                          out_last_q;
	rsdm_pkg::action_t             route_act;
	logic                          last_next;

	always_comb begin
		if (p_str_q == cfg.video) route_act = rsdm_pkg::ACT_VIDEO;
		else if (p_str_q == cfg.audio) route_act = rsdm_pkg::ACT_AUDIO;
		else route_act = rsdm_pkg::ACT_OTHER;
	end

	assign last_next = mode_q ? ((res_cnt_q == rsdm_pkg::RES_W'(rsdm_pkg::MAX_RES-1)) ||
		!head_due) : 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			res_cnt_q   <= '0;
		end else begin
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (cmd.latch_in) res_cnt_q <= '0;
			else if (cmd.emit) res_cnt_q <= res_cnt_q + rsdm_pkg::RES_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (cmd.kind)
				rsdm_pkg::EK_FULL: begin
					out_tag_q <= tag_q;
					out_str_q <= stream_q;
					out_act_q <= rsdm_pkg::ACT_FULL;
				end
				rsdm_pkg::EK_DUP: begin
					out_tag_q <= p_tag_q;
					out_str_q <= p_str_q;
					out_act_q <= rsdm_pkg::ACT_DUP;
				end
				default: begin
					out_tag_q <= p_tag_q;
					out_str_q <= p_str_q;
					out_act_q <= route_act;
				end
			endcase
			out_last_q <= last_next;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_tag    = out_tag_q;
	assign out_stream = out_str_q;
	assign out_action = out_act_q;
	assign out_last   = out_last_q;
	assign hold_cnt   = hold_cnt_q;
	assign seen_cnt   = scnt_q;

	// Status back to the controller
	assign sts.is_push     = !mode_q;
	assign sts.hold_full   = (hold_cnt_q == HC_W'(HOLD_DEPTH));
	assign sts.can_pop     = head_due && (res_cnt_q != rsdm_pkg::RES_W'(rsdm_pkg::MAX_RES));
	assign sts.key_present = p_kp_q;
	assign sts.seen_empty  = (scnt_q == '0);
	assign sts.exp_due     = (rd_q.expiry <= now_q);
	assign sts.scan_done   = (scan_i_q == scnt_q);
	assign sts.match       = (rd_q.key == p_key_q) && (rd_q.stream == p_str_q);
	assign sts.out_free    = !out_valid_q || out_ready;

endmodule

[hdl/rsdm_ctrl.sv]
// Controller state machine: sequences insertion, release, expiry, lookup and result beats.
module rsdm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rsdm_pkg::sts_t sts,
	output rsdm_pkg::cmd_t cmd
);

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_START   = 9'b000000010,
		S_CHECK   = 9'b000000100,
		S_EXP_RD  = 9'b000001000,
		S_EXP_CMP = 9'b000010000,
		S_LK_CHK  = 9'b000100000,
		S_LK_CMP  = 9'b001000000,
		S_ADD     = 9'b010000000,
		S_EMIT    = 9'b100000000
	} state_t;

	state_t                 state_q, state_d;
	rsdm_pkg::emit_kind_t   kind_q, kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= rsdm_pkg::EK_ROUTE;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		kind_d   = kind_q;
		cmd      = '0;
		cmd.kind = kind_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_START;
				end
			end
			S_START: begin
				if (!sts.is_push) begin
					state_d = S_CHECK;
				end else if (sts.hold_full) begin
					kind_d  = rsdm_pkg::EK_FULL;
					state_d = S_EMIT;
				end else begin
					cmd.insert = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_CHECK: begin
				if (sts.can_pop) begin
					cmd.pop = 1'b1;
					state_d = S_EXP_RD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_EXP_RD: begin
				if (!sts.seen_empty) begin
					cmd.exp_rd = 1'b1;
					state_d    = S_EXP_CMP;
				end else if (sts.key_present) begin
					cmd.lk_start = 1'b1;
					state_d      = S_LK_CHK;
				end else begin
					kind_d  = rsdm_pkg::EK_ROUTE;
					state_d = S_EMIT;
				end
			end
			S_EXP_CMP: begin
				if (sts.exp_due) begin
					cmd.exp_adv = 1'b1;
					state_d     = S_EXP_RD;
				end else if (sts.key_present) begin
					cmd.lk_start = 1'b1;
					state_d      = S_LK_CHK;
				end else begin
					kind_d  = rsdm_pkg::EK_ROUTE;
					state_d = S_EMIT;
				end
			end
			S_LK_CHK: begin
				if (sts.scan_done) begin
					state_d = S_ADD;
				end else begin
					cmd.lk_rd = 1'b1;
					state_d   = S_LK_CMP;
				end
			end
			S_LK_CMP: begin
				if (sts.match) begin
					kind_d  = rsdm_pkg::EK_DUP;
					state_d = S_EMIT;
				end else begin
					state_d = S_LK_CHK;
				end
			end
			S_ADD: begin
				cmd.seen_add = 1'b1;
				kind_d       = rsdm_pkg::EK_ROUTE;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = sts.is_push ? S_IDLE : S_CHECK;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[hdl/redundant_stream_dedup_merger.sv]
// Top level: stream ports, configuration registers, controller and datapath.
// Push: sorted into the buffer from the START state; the next item is taken back in IDLE.
//   A full buffer gives one beat instead.
// Tick: decoded in START, then each released packet is popped, expired seen entries dropped
//   in turn and the table scanned entry by entry in the one-port seen memory; at most 32 beats.
// One item at a time; a new item is accepted while the last result beat waits.
// Reset (arst_n low) clears counters, pointers and valid flags; stores hold no valid bits.
module redundant_stream_dedup_merger #(
	parameter int HOLD_DEPTH = 32,
	parameter int SEEN_DEPTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// now[47:0], packet_tag[63:48], stream[71:64], pts[135:72], pts_valid[136],
	// dts[200:137], dts_valid[201], zero fill
	input  logic [207:0] s_axis_tdata,
	// mode[0]
	input  logic [0:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_tag[15:0], out_stream[23:16], action[26:24], zero fill
	output logic [31:0]  m_axis_tdata,
	output logic         m_axis_tlast,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	rsdm_pkg::cfg_t    cfg_q;
	rsdm_pkg::in_t     in_item;
	rsdm_pkg::cmd_t    cmd;
	rsdm_pkg::sts_t    sts;
	rsdm_pkg::action_t out_action;
	logic [rsdm_pkg::TAG_W-1:0]    out_tag;
	logic [rsdm_pkg::STREAM_W-1:0] out_stream;
	logic [$clog2(HOLD_DEPTH+1)-1:0] hold_cnt;
	logic [$clog2(SEEN_DEPTH+1)-1:0] seen_cnt;
	logic cfg_wr;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window <= rsdm_pkg::WIN_W'(1000);
			cfg_q.video  <= '0;
			cfg_q.audio  <= rsdm_pkg::STREAM_W'(1);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				rsdm_pkg::REG_WINDOW: cfg_q.window <= pwdata[rsdm_pkg::WIN_W-1:0];
				rsdm_pkg::REG_VIDEO:  cfg_q.video  <= pwdata[rsdm_pkg::STREAM_W-1:0];
				rsdm_pkg::REG_AUDIO:  cfg_q.audio  <= pwdata[rsdm_pkg::STREAM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			rsdm_pkg::REG_WINDOW: prdata = 32'(cfg_q.window);
			rsdm_pkg::REG_VIDEO:  prdata = 32'(cfg_q.video);
			rsdm_pkg::REG_AUDIO:  prdata = 32'(cfg_q.audio);
			default:              prdata = '0;
		endcase
	end

	// Unpack the input beat
	assign in_item.mode      = s_axis_tuser[0];
	assign in_item.now       = s_axis_tdata[47:0];
	assign in_item.tag       = s_axis_tdata[63:48];
	assign in_item.stream    = s_axis_tdata[71:64];
	assign in_item.pts       = s_axis_tdata[135:72];
	assign in_item.pts_valid = s_axis_tdata[136];
	assign in_item.dts       = s_axis_tdata[200:137];
	assign in_item.dts_valid = s_axis_tdata[201];

	rsdm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rsdm_dp #(
		.HOLD_DEPTH (HOLD_DEPTH),
		.SEEN_DEPTH (SEEN_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_item    (in_item),
		.cfg        (cfg_q),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_tag    (out_tag),
		.out_stream (out_stream),
		.out_action (out_action),
		.out_last   (m_axis_tlast),
		.hold_cnt   (hold_cnt),
		.seen_cnt   (seen_cnt)
	);

	// Pack the output beat
	assign m_axis_tdata = {5'b0, out_action, out_stream, out_tag};

	// Occupancy never passes the store sizes
	a_hold_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(hold_cnt) <= HOLD_DEPTH)
		else $error("hold buffer count above depth");

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(seen_cnt) <= SEEN_DEPTH)
		else $error("seen table count above depth");

	// An accepted beat makes the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while previous item still in work");

	// Insertion only with room in the buffer
	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> !sts.hold_full)
		else $error("insert into full hold buffer");

endmodule

[verif/redundant_stream_dedup_merger_check.sv]
// Monitor, dedup-merger predictor and scoreboard for the redundant stream merger.
`timescale 1ns / 100ps
module redundant_stream_dedup_merger_check (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [207:0] s_axis_tdata,
	input  logic [0:0]   s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [31:0]  m_axis_tdata,
	input  logic         m_axis_tlast,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	output int           fail_count,
	output int           pending_count,
	output int           beat_count
);

	localparam int HOLD_N = 32;
	localparam int SEEN_N = 64;
	localparam int TW     = rsdm_pkg::TIME_W;

	typedef struct {
		logic [rsdm_pkg::TAG_W-1:0]    tag;
		logic [rsdm_pkg::STREAM_W-1:0] stream;
		rsdm_pkg::action_t             act;
		logic                          last;
	} verdict_t;

	typedef struct {
		logic [rsdm_pkg::KEY_W-1:0]    key;
		logic                          present;
		logic [rsdm_pkg::TAG_W-1:0]    tag;
		logic [rsdm_pkg::STREAM_W-1:0] stream;
		logic [TW-1:0]                 arrival;
	} held_t;

	// Model state
	logic [rsdm_pkg::WIN_W-1:0]    window_q;
	logic [rsdm_pkg::STREAM_W-1:0] video_q, audio_q;
	held_t                         held[$];
	logic [rsdm_pkg::KEY_W-1:0]    seen_key[SEEN_N];
	logic [rsdm_pkg::STREAM_W-1:0] seen_stream[SEEN_N];
	logic [TW-1:0]                 seen_expiry[SEEN_N];
	int                            seen_head, seen_cnt;
	verdict_t                      verdicts[$];

	task automatic report(input string what);
		fail_count++;
		$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	function automatic bit key_before(held_t a, held_t b);
		if (!a.present) return b.present;
		if (!b.present) return 1'b0;
		return $signed(a.key) < $signed(b.key);
	endfunction

	task automatic add_verdict(logic [rsdm_pkg::TAG_W-1:0] t,
			logic [rsdm_pkg::STREAM_W-1:0] s, rsdm_pkg::action_t a);
		verdict_t v;
		v.tag = t; v.stream = s; v.act = a; v.last = 1'b0;
		verdicts.insert(verdicts.size(), v);
	endtask

	// Predict the verdicts caused by one accepted item
	task automatic predict_merge(input rsdm_pkg::in_t it);
		held_t h, top;
		int pos, n, j;
		bit dup;
		logic [TW:0] exp;
		if (!it.mode) begin
			h.present = it.pts_valid | it.dts_valid;
			h.key = it.pts_valid ? it.pts : (it.dts_valid ? it.dts : '0);
			h.tag = it.tag; h.stream = it.stream; h.arrival = it.now;
			if (held.size() >= HOLD_N) begin
				add_verdict(it.tag, it.stream, rsdm_pkg::ACT_FULL);
				verdicts[$].last = 1'b1;
				return;
			end
			pos = held.size();
			foreach (held[i])
				if (key_before(h, held[i])) begin
					pos = i;
					break;
				end
			held.insert(pos, h);
			return;
		end
		n = 0;
		while (held.size() > 0 && n < rsdm_pkg::MAX_RES) begin
			top = held[0];
			if (it.now < top.arrival || it.now - top.arrival < TW'(window_q)) break;
			held.delete(0);
			while (seen_cnt > 0 && seen_expiry[seen_head] <= it.now) begin
				seen_head = (seen_head + 1) % SEEN_N;
				seen_cnt--;
			end
			dup = 0;
			if (top.present)
				for (int i = 0; i < seen_cnt; i++) begin
					j = (seen_head + i) % SEEN_N;
					if (seen_key[j] == top.key && seen_stream[j] == top.stream) dup = 1;
				end
			n++;
			if (dup) begin
				add_verdict(top.tag, top.stream, rsdm_pkg::ACT_DUP);
				continue;
			end
			if (top.present) begin
				exp = {1'b0, it.now} + (TW+1)'({window_q, 1'b0});
				if (exp[TW]) exp = {1'b0, {TW{1'b1}}};
				if (seen_cnt >= SEEN_N) begin
					seen_head = (seen_head + 1) % SEEN_N;
					seen_cnt = SEEN_N - 1;
				end
				j = (seen_head + seen_cnt) % SEEN_N;
				seen_key[j] = top.key;
				seen_stream[j] = top.stream;
				seen_expiry[j] = exp[TW-1:0];
				seen_cnt++;
			end
			if (top.stream == video_q)
				add_verdict(top.tag, top.stream, rsdm_pkg::ACT_VIDEO);
			else if (top.stream == audio_q)
				add_verdict(top.tag, top.stream, rsdm_pkg::ACT_AUDIO);
			else
				add_verdict(top.tag, top.stream, rsdm_pkg::ACT_OTHER);
		end
		if (n > 0) verdicts[$].last = 1'b1;
	endtask

	// Watch the channels
	always @(posedge clk or negedge arst_n) begin
		rsdm_pkg::in_t it;
		verdict_t      v;
		if (!arst_n) begin
			window_q <= 24'd1000;
			video_q <= 8'd0;
			audio_q <= 8'd1;
			held.delete();
			verdicts.delete();
			seen_head = 0;
			seen_cnt = 0;
			fail_count = 0;
			beat_count = 0;
			pending_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					rsdm_pkg::REG_WINDOW: window_q <= pwdata[rsdm_pkg::WIN_W-1:0];
					rsdm_pkg::REG_VIDEO:  video_q <= pwdata[rsdm_pkg::STREAM_W-1:0];
					rsdm_pkg::REG_AUDIO:  audio_q <= pwdata[rsdm_pkg::STREAM_W-1:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				beat_count++;
				if (verdicts.size() == 0) begin
					report($sformatf("unexpected beat %h", m_axis_tdata));
				end else begin
					v = verdicts[0];
					verdicts.delete(0);
					if (m_axis_tdata[15:0] !== v.tag)
						report($sformatf("tag %h want %h", m_axis_tdata[15:0], v.tag));
					if (m_axis_tdata[23:16] !== v.stream)
						report($sformatf("stream %h want %h", m_axis_tdata[23:16], v.stream));
					if (m_axis_tdata[26:24] !== v.act)
						report($sformatf("action %0d want %0d tag %h",
							m_axis_tdata[26:24], v.act, v.tag));
					if (m_axis_tlast !== v.last)
						report($sformatf("tlast %b want %b tag %h", m_axis_tlast, v.last, v.tag));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				it.mode = s_axis_tuser[0];
				it.now = s_axis_tdata[47:0];
				it.tag = s_axis_tdata[63:48];
				it.stream = s_axis_tdata[71:64];
				it.pts = s_axis_tdata[135:72];
				it.pts_valid = s_axis_tdata[136];
				it.dts = s_axis_tdata[200:137];
				it.dts_valid = s_axis_tdata[201];
				predict_merge(it);
			end
			pending_count = verdicts.size();
		end
	end

endmodule

[verif/redundant_stream_dedup_merger_test.sv]
// Top of the merger testbench: clock, reset, register writes and packet/tick stimulus.
`timescale 1ns / 100ps
module redundant_stream_dedup_merger_test;

	localparam int WATCHDOG = 20000;
	localparam int TW       = rsdm_pkg::TIME_W;

	logic         clk, arst_n;
	logic         s_axis_tvalid, s_axis_tready;
	logic [207:0] s_axis_tdata;
	logic [0:0]   s_axis_tuser;
	logic         m_axis_tvalid, m_axis_tready, m_axis_tlast;
	logic [31:0]  m_axis_tdata, prdata, pwdata;
	logic         psel, penable, pwrite, pready;
	logic [3:0]   paddr;
	int           fail_count, pending_count, beat_count;
	int           idle_cycles, items_sent;
	bit           calm, backpressure, timed_out;
	logic [TW-1:0] clock_now;

	redundant_stream_dedup_merger dut (.*);
	redundant_stream_dedup_merger_check monitor (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Result side: random stalls, one long hold-off, none late in the run
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (backpressure) begin
				m_axis_tready <= 1'b0;
				repeat (400) @(posedge clk);
				backpressure = 0;
			end
			if (!calm && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// Watchdog on cycles without any handshake
	initial begin
		idle_cycles = 0;
		timed_out = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			    backpressure || !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				timed_out = 1;
				$display("redundant_stream_dedup_merger_test: errors");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// Drive one item and wait for its acceptance; valid stays up for the next item
	task automatic send(input rsdm_pkg::in_t it);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.mode;
		s_axis_tdata <= {6'b0, it.dts_valid, it.dts, it.pts_valid, it.pts,
			it.stream, it.tag, it.now};
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	task automatic push_pkt(input logic [rsdm_pkg::TAG_W-1:0] tg,
			input logic [rsdm_pkg::STREAM_W-1:0] st,
			input logic [rsdm_pkg::KEY_W-1:0] k, input logic [1:0] kv);
		rsdm_pkg::in_t it;
		it.mode = 1'b0; it.now = clock_now; it.tag = tg; it.stream = st;
		it.pts = k; it.pts_valid = kv[0];
		it.dts = kv[0] ? {$urandom, $urandom} : k; it.dts_valid = kv[1];
		send(it);
	endtask

	task automatic tick(input logic [TW-1:0] t);
		rsdm_pkg::in_t it;
		it = '0;
		it.mode = 1'b1; it.now = t;
		it.tag = rsdm_pkg::TAG_W'($urandom); it.stream = rsdm_pkg::STREAM_W'($urandom);
		send(it);
	endtask

	// Drop valid, then wait for all results and a quiet stretch
	task automatic settle;
		s_axis_tvalid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	initial begin
		logic [rsdm_pkg::KEY_W-1:0] k;
		arst_n = 0;
		s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		calm = 0; backpressure = 0; items_sent = 0; clock_now = 100;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: key extremes, fallback and absent keys, routing, repeats
		write_reg(rsdm_pkg::REG_WINDOW, 32'd10);
		write_reg(rsdm_pkg::REG_VIDEO, 32'd5);
		write_reg(rsdm_pkg::REG_AUDIO, 32'd7);
		push_pkt(16'hffff, 8'd5, 64'h7fffffffffffffff, 2'b01);
		push_pkt(16'h0000, 8'd7, 64'h8000000000000001, 2'b11);
		push_pkt(16'h0001, 8'd5, 64'h0, 2'b10);
		push_pkt(16'h0002, 8'd9, 64'h0, 2'b00);
		push_pkt(16'h0003, 8'd255, 64'h0, 2'b00);
		push_pkt(16'h0004, 8'd5, 64'h7fffffffffffffff, 2'b01);
		push_pkt(16'h0005, 8'd7, 64'h8000000000000001, 2'b10);
		tick(clock_now + 48'd5);
		tick(clock_now - 48'd50);
		tick(clock_now + 48'd10);
		tick(48'hffffffffffff);
		settle();

		// Fill the buffer to overflow, then drain in ticks limited to 32
		write_reg(rsdm_pkg::REG_WINDOW, 32'd0);
		clock_now = 48'hfffffffff000;
		for (int i = 0; i < 34; i++)
			push_pkt(rsdm_pkg::TAG_W'(i), i[0] ? 8'd0 : 8'd1, rsdm_pkg::KEY_W'(i % 5), 2'b01);
		tick(clock_now);
		tick(clock_now);
		settle();

		// Random: redundant pairs with hold window, seen expiry and overflow
		write_reg(rsdm_pkg::REG_WINDOW, 32'hffffff);
		write_reg(rsdm_pkg::REG_VIDEO, 32'd0);
		write_reg(rsdm_pkg::REG_AUDIO, 32'd255);
		clock_now = 48'hffffff000000;
		for (int i = 0; i < 12; i++)
			push_pkt(rsdm_pkg::TAG_W'($urandom), $urandom_range(0, 1) ? 8'd0 : 8'd255,
				{$urandom, $urandom}, 2'($urandom));
		tick(48'hffffffffffff);
		settle();
		write_reg(rsdm_pkg::REG_WINDOW, 32'd20);
		write_reg(rsdm_pkg::REG_VIDEO, 32'd0);
		write_reg(rsdm_pkg::REG_AUDIO, 32'd1);
		clock_now = 1000;
		for (int n = 0; n < 176; n++) begin
			if (n == 90) backpressure = 1;
			if (n == 150) calm = 1;
			case ($urandom_range(0, 9))
				0: begin
					if ($urandom_range(0, 1) != 0)
						tick(clock_now - TW'($urandom_range(0, 40)));
					else
						tick(TW'({$urandom, $urandom}));
				end
				1, 2: begin
					clock_now += TW'($urandom_range(0, 30));
					tick(clock_now);
				end
				3: push_pkt(rsdm_pkg::TAG_W'($urandom), rsdm_pkg::STREAM_W'($urandom),
					{$urandom, $urandom}, 2'($urandom));
				default: begin
					k = rsdm_pkg::KEY_W'($signed($urandom_range(0, 40)) - 20);
					clock_now += TW'($urandom_range(0, 4));
					push_pkt(rsdm_pkg::TAG_W'($urandom),
						rsdm_pkg::STREAM_W'($urandom_range(0, 2)), k, 2'($urandom_range(1, 3)));
					if ($urandom_range(0, 2) != 0)
						push_pkt(rsdm_pkg::TAG_W'($urandom),
							rsdm_pkg::STREAM_W'($urandom_range(0, 2)), k,
							2'($urandom_range(1, 3)));
				end
			endcase
		end
		tick(48'hffffffffffff);
		tick(48'hffffffffffff);
		settle();

		$display("Sent %0d items (packets, ticks, overflow, key extremes), checked %0d beats;",
			items_sent, beat_count);
		$display("three register settings including window 0 and max, one long output stall.");
		if (fail_count == 0)
			$display("redundant_stream_dedup_merger_test: clean");
		else
			$display("redundant_stream_dedup_merger_test: errors");
		$finish;
	end

endmodule
